// File: src/clfa_pkg.sv
// Package for the complex list fold ALU: input and result transfer structs.
// No dependencies.
package clfa_pkg;

    typedef struct packed {
        logic signed [31:0] in_real;
        logic signed [31:0] in_imag;
        logic               last_item;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sum_real;
        logic signed [31:0] sum_imag;
        logic signed [31:0] diff_real;
        logic signed [31:0] diff_imag;
        logic signed [31:0] prod_real;
        logic signed [31:0] prod_imag;
        logic signed [31:0] quot_real;
        logic signed [31:0] quot_imag;
        logic               zero_divisor;
        logic               saturated;
    } out_item_t;

endpackage

// File: src/complex_list_fold_alu.sv
// Top level of the complex list fold ALU: folds a list of fixed-point complex
// numbers into sum, difference, product and quotient accumulators.
// Depends on clfa_pkg.
//
//  channel | valid      | stall      | payload
//  input   | in_valid   | in_stall   | in_data  (clfa_pkg::in_item_t)
//  output  | out_valid  | out_stall  | out_data (clfa_pkg::out_item_t)
//
// The first item of a list only loads the accumulators and leaves the block idle. A
// later item keeps the block busy through the accept cycle, the bit-serial shift-add
// multiplier, a load cycle and the restoring divide steps that retire one quotient bit
// per cycle for both parts, and a write-back cycle that can wait on a held result.
// Reset clears control state and the sum, difference, product and quotient accumulators. A result waits in the output
// register while later items of the next list are folded; the first item of a list
// and the write-back of a last item wait until a held result has been transferred.
module complex_list_fold_alu #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  clfa_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output clfa_pkg::out_item_t out_data
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W + 2;
    localparam int NW = PW + FRAC_BITS;
    localparam int QN = NW;
    localparam int SW = NW + 2;
    localparam int CW = $clog2(QN + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic list_open_reg;
    logic last_reg;
    logic zdiv_reg, sat_reg;
    logic signed [W-1:0] sre_reg, sim_reg, dre_reg, dim_reg;
    logic signed [W-1:0] pre_reg, pim_reg, qre_reg, qim_reg;
    logic signed [W-1:0] c_reg, d_reg;
    logic [W-1:0] mult_reg;
    logic signed [PW-1:0] ac_reg, bd_reg, ad_reg, bc_reg, qac_reg, qbd_reg;
    logic signed [PW-1:0] qad_reg, qbc_reg, den_acc_reg, den_acc2_reg;
    logic [NW-1:0] nre_reg, nim_reg;
    logic [PW-1:0] remr_reg, remi_reg, den_reg;
    logic nre_neg_reg, nim_neg_reg;
    logic out_valid_reg;
    clfa_pkg::out_item_t out_reg;

    wire out_busy  = out_valid_reg && out_stall;
    wire done_hold = last_reg && out_busy;

    assign in_stall  = (state_reg != ST_IDLE) || (out_busy && !list_open_reg);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    wire accept = in_valid && !in_stall;
    wire signed [W-1:0] c_in = W'($unsigned(in_data.in_real));
    wire signed [W-1:0] d_in = W'($unsigned(in_data.in_imag));
    wire out_load = ((state_reg == ST_IDLE) && accept && !list_open_reg
                     && in_data.last_item)
                    || ((state_reg == ST_DONE) && last_reg && !done_hold);

    function automatic logic [31:0] fld(input logic [W-1:0] x);
        fld = 32'(x);
    endfunction

    function automatic logic signed [W-1:0] sat_v(input logic signed [SW-1:0] v,
                                                  output logic ov);
        logic signed [SW-1:0] mx, mn;
        begin
            mx = SW'({1'b0, {(W-1){1'b1}}});
            mn = -mx - SW'(1);
            ov = (v > mx) || (v < mn);
            sat_v = (v > mx) ? mx[W-1:0] : (v < mn) ? mn[W-1:0] : v[W-1:0];
        end
    endfunction

    // One multiplier bit per cycle: the mult_reg bit of c (first pass) selects
    // partial sums against the accumulators.
    wire mb = mult_reg[0];
    wire top_step = (cnt_reg == CW'(W - 1));
    function automatic logic signed [PW-1:0] pp(input logic signed [W-1:0] x,
                                                input logic b, input logic top,
                                                input logic [CW-1:0] sh);
        logic signed [PW-1:0] t;
        begin
            t = b ? (PW'(x) <<< sh) : '0;
            pp = top ? -t : t;
        end
    endfunction

    logic [PW:0] tr_re, tr_im;
    logic ovs [0:7];
    logic signed [W-1:0] nv [0:7];
    logic signed [PW-1:0] pr_round, pi_round;

    always_comb
    begin
        tr_re = {remr_reg, nre_reg[NW-1]} - {1'b0, den_reg};
        tr_im = {remi_reg, nim_reg[NW-1]} - {1'b0, den_reg};
        pr_round = (ac_reg - bd_reg + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        pi_round = (ad_reg + bc_reg + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        nv[0] = sat_v(SW'(sre_reg) + SW'(c_reg), ovs[0]);
        nv[1] = sat_v(SW'(sim_reg) + SW'(d_reg), ovs[1]);
        nv[2] = sat_v(SW'(dre_reg) - SW'(c_reg), ovs[2]);
        nv[3] = sat_v(SW'(dim_reg) - SW'(d_reg), ovs[3]);
        nv[4] = sat_v(SW'(pr_round), ovs[4]);
        nv[5] = sat_v(SW'(pi_round), ovs[5]);
        nv[6] = sat_v(nre_neg_reg ? -SW'(nre_reg) : SW'(nre_reg), ovs[6]);
        nv[7] = sat_v(nim_neg_reg ? -SW'(nim_reg) : SW'(nim_reg), ovs[7]);
    end

    logic signed [PW-1:0] numr, numi;
    always_comb
    begin
        numr = qac_reg + qbd_reg;
        numi = qbc_reg - qad_reg;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept && list_open_reg) state_next = ST_MUL;
            ST_MUL:  if (top_step) state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == CW'(QN)) state_next = ST_DONE;
            ST_DONE: if (!done_hold) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            list_open_reg <= 1'b0;
            cnt_reg <= '0;
            last_reg <= 1'b0;
            zdiv_reg <= 1'b0;
            sat_reg <= 1'b0;
            sre_reg <= '0; sim_reg <= '0; dre_reg <= '0; dim_reg <= '0;
            pre_reg <= '0; pim_reg <= '0; qre_reg <= '0; qim_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        c_reg <= c_in;
                        d_reg <= d_in;
                        mult_reg <= c_in;
                        last_reg <= in_data.last_item;
                        cnt_reg <= '0;
                        ac_reg <= '0; bd_reg <= '0; ad_reg <= '0; bc_reg <= '0;
                        qac_reg <= '0; qbd_reg <= '0; qad_reg <= '0; qbc_reg <= '0;
                        den_acc_reg <= '0; den_acc2_reg <= '0;
                        if (!list_open_reg)
                        begin
                            sre_reg <= c_in; dre_reg <= c_in; pre_reg <= c_in;
                            qre_reg <= c_in;
                            sim_reg <= d_in; dim_reg <= d_in; pim_reg <= d_in;
                            qim_reg <= d_in;
                            zdiv_reg <= 1'b0;
                            sat_reg <= 1'b0;
                            list_open_reg <= !in_data.last_item;
                            if (in_data.last_item)
                            begin
                                out_reg <= '{sum_real: fld(c_in), sum_imag: fld(d_in),
                                    diff_real: fld(c_in), diff_imag: fld(d_in),
                                    prod_real: fld(c_in), prod_imag: fld(d_in),
                                    quot_real: fld(c_in), quot_imag: fld(d_in),
                                    zero_divisor: 1'b0, saturated: 1'b0};
                            end
                        end
                    end
                end
                ST_MUL:
                begin
                    // Bit cnt of c drives ac, bc, qac, qbc and c*c;
                    // bit cnt of d drives bd, ad, qbd, qad and d*d.
                    ac_reg  <= ac_reg  + pp(pre_reg, mb, top_step, cnt_reg);
                    bc_reg  <= bc_reg  + pp(pim_reg, mb, top_step, cnt_reg);
                    qac_reg <= qac_reg + pp(qre_reg, mb, top_step, cnt_reg);
                    qbc_reg <= qbc_reg + pp(qim_reg, mb, top_step, cnt_reg);
                    den_acc_reg <= den_acc_reg + pp(c_reg, mb, top_step, cnt_reg);
                    bd_reg  <= bd_reg  + pp(pim_reg, d_reg[cnt_reg[$clog2(W)-1:0]],
                                            top_step, cnt_reg);
                    ad_reg  <= ad_reg  + pp(pre_reg, d_reg[cnt_reg[$clog2(W)-1:0]],
                                            top_step, cnt_reg);
                    qbd_reg <= qbd_reg + pp(qim_reg, d_reg[cnt_reg[$clog2(W)-1:0]],
                                            top_step, cnt_reg);
                    qad_reg <= qad_reg + pp(qre_reg, d_reg[cnt_reg[$clog2(W)-1:0]],
                                            top_step, cnt_reg);
                    den_acc2_reg <= den_acc2_reg + pp(d_reg, d_reg[cnt_reg[$clog2(W)-1:0]],
                                                      top_step, cnt_reg);
                    mult_reg <= mult_reg >> 1;
                    cnt_reg <= top_step ? '0 : cnt_reg + CW'(1);
                    if (top_step)
                    begin
                        remr_reg <= '0;
                        remi_reg <= '0;
                    end
                end
                ST_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        // Load magnitudes of the numerators, scaled by 2^F.
                        den_reg <= PW'(den_acc_reg + den_acc2_reg);
                        nre_neg_reg <= numr[PW-1];
                        nim_neg_reg <= numi[PW-1];
                        nre_reg <= NW'(numr[PW-1] ? -numr : numr) << FRAC_BITS;
                        nim_reg <= NW'(numi[PW-1] ? -numi : numi) << FRAC_BITS;
                    end
                    else
                    begin
                        if (!tr_re[PW]) remr_reg <= tr_re[PW-1:0];
                        else remr_reg <= {remr_reg[PW-2:0], nre_reg[NW-1]};
                        if (!tr_im[PW]) remi_reg <= tr_im[PW-1:0];
                        else remi_reg <= {remi_reg[PW-2:0], nim_reg[NW-1]};
                        nre_reg <= {nre_reg[NW-2:0], !tr_re[PW]};
                        nim_reg <= {nim_reg[NW-2:0], !tr_im[PW]};
                    end
                    cnt_reg <= cnt_reg + CW'(1);
                end
                ST_DONE:
                begin
                    if (!done_hold)
                    begin
                        sre_reg <= nv[0]; sim_reg <= nv[1];
                        dre_reg <= nv[2]; dim_reg <= nv[3];
                        pre_reg <= nv[4]; pim_reg <= nv[5];
                        if (den_reg == '0)
                        begin
                            zdiv_reg <= 1'b1;
                        end
                        else
                        begin
                            qre_reg <= nv[6];
                            qim_reg <= nv[7];
                        end
                        list_open_reg <= !last_reg;
                        if (last_reg)
                        begin
                            out_reg <= '{sum_real: fld(nv[0]), sum_imag: fld(nv[1]),
                                diff_real: fld(nv[2]), diff_imag: fld(nv[3]),
                                prod_real: fld(nv[4]), prod_imag: fld(nv[5]),
                                quot_real: fld((den_reg == '0) ? qre_reg : nv[6]),
                                quot_imag: fld((den_reg == '0) ? qim_reg : nv[7]),
                                zero_divisor: zdiv_reg || (den_reg == '0),
                                saturated: sat_reg || ovs[0] || ovs[1] || ovs[2] || ovs[3]
                                    || ovs[4] || ovs[5]
                                    || ((den_reg != '0) && (ovs[6] || ovs[7]))};
                        end
                        sat_reg <= sat_reg || ovs[0] || ovs[1] || ovs[2] || ovs[3]
                            || ovs[4] || ovs[5] || ((den_reg != '0) && (ovs[6] || ovs[7]));
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !done_hold) |=> (state_reg == ST_IDLE))
        else $error("done state not left");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_MUL || state_reg == ST_DIV))
        else $error("multiply phase left early");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

endmodule
